// ===== rtl/brs_pkg.sv =====
// Shared types and constants for the block-decomposed range-sum store.
// Used by the top level, the generic RAM wrapper users and the port checker.
// No dependencies.
package brs_pkg;

  // fixed field widths of the stream words
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned DATA_W = 64;

  // slave tdata: position, range_end, value, padded to whole bytes
  localparam int unsigned IN_FIELDS_W = 2 * POS_W + DATA_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  // default geometry
  localparam int unsigned DEPTH_DEF       = 1024;
  localparam int unsigned BLOCK_WIDTH_DEF = 32;

  // command codes carried on the slave tuser
  typedef enum logic [CMD_W-1:0] {
    CmdWrite = 2'd0,
    CmdAdd   = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  // sequencer states
  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StDecode,
    StBound,
    StRead,
    StUpdate,
    StBlkWr,
    StScan,
    StDrain,
    StResult
  } state_e;

  // query scan phases
  typedef enum logic [1:0] {
    PhHead,
    PhBlocks,
    PhTail
  } phase_e;

endpackage

// ===== rtl/brs_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read data holds while no read is requested. No package dependencies.
module brs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/block_decomposed_range_sum.sv =====
// Block-decomposed range-sum store: element memory plus per-block sum memory.
// Commands arrive one word at a time on the slave stream; a query returns one
// word on the master stream, write and add return nothing.
//
// After reset a clearing pass zeroes both memories, one entry a cycle;
// s_axis_tready stays low during that pass.
// Write and add are a read-modify-write of the element and of its block sum,
// stepped through the decode, read, update and block-write states; then the next word is taken.
// A query walks the head partial block element by element, then the whole
// blocks in between through their stored sums, then the tail partial block,
// one memory read a cycle, at most 2*BLOCK_WIDTH + DEPTH/BLOCK_WIDTH - 2 reads in all.
// The single read port of each memory sets that rate.
// One word is in work at a time. The result sits in an output register; the
// next command is accepted while it waits. A query that finishes while the
// previous result is still not taken holds until the master side accepts.
// Depends on brs_pkg and brs_ram.
module block_decomposed_range_sum #(
  parameter int unsigned DEPTH       = brs_pkg::DEPTH_DEF,
  parameter int unsigned BLOCK_WIDTH = brs_pkg::BLOCK_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [9:0] position, [19:10] range_end, [83:20] value, [87:84] zero
  input  logic [brs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] command
  input  logic [brs_pkg::CMD_W-1:0]       s_axis_tuser,
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [63:0] range_sum
  output logic [brs_pkg::DATA_W-1:0]      m_axis_tdata,
  // [0] range_error
  output logic                            m_axis_tuser
);
  import brs_pkg::*;

  // geometry
  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = (AW > POS_W) ? AW : POS_W;
  localparam int unsigned CXW = CW + 1;
  localparam int unsigned NB  = (DEPTH + BLOCK_WIDTH - 1) / BLOCK_WIDTH;
  localparam int unsigned BAW = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned BL  = $clog2(BLOCK_WIDTH);
  localparam int unsigned BXW = BAW + BL + 1;
  // index / BLOCK_WIDTH as a multiply by a rounded-up reciprocal, exact for AW-bit indexes
  localparam int unsigned SH    = AW + BL;
  localparam longint unsigned RECIP = ((64'd1 << SH) + BLOCK_WIDTH - 1) / BLOCK_WIDTH;
  localparam int unsigned PW    = 2 * AW + 10;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  cmd_e              cmd_q;
  logic [CW-1:0]     pos_q, end_q;
  logic [DATA_W-1:0] value_q;
  logic [BAW-1:0]    sb_q, sb_d, eb_q, eb_d;
  logic [AW-1:0]     head_last_q, head_last_d, tail_first_q, tail_first_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [BAW-1:0]    bidx_q, bidx_d;
  logic              rdv_q, rdv_d, rdsrc_q, rdsrc_d;
  logic [DATA_W-1:0] acc_q, acc_d, diff_q, diff_d;
  logic              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_sum_q, out_sum_d;
  logic              out_err_q, out_err_d;

  // memory ports
  logic              el_we, el_re, blk_we, blk_re;
  logic [AW-1:0]     el_waddr, el_raddr;
  logic [BAW-1:0]    blk_waddr, blk_raddr;
  logic [DATA_W-1:0] el_wdata, el_rdata, blk_wdata, blk_rdata;

  logic              in_accept;
  logic              pos_out, end_out;
  logic [AW-1:0]     end_c;
  logic [PW-1:0]     sb_prod, eb_prod;
  logic [BXW-1:0]    head_edge, tail_edge;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // range checks and clamped end
  assign pos_out = {1'b0, pos_q} >= CXW'(DEPTH);
  assign end_out = {1'b0, end_q} >= CXW'(DEPTH);
  assign end_c   = end_out ? AW'(DEPTH - 1) : end_q[AW-1:0];

  // block numbers of start and clamped end
  assign sb_prod = PW'(pos_q[AW-1:0]) * PW'(RECIP);
  assign eb_prod = PW'(end_c) * PW'(RECIP);

  // head block last element and tail block first element
  assign head_edge = (BXW'(sb_q) + BXW'(1)) * BXW'(BLOCK_WIDTH) - BXW'(1);
  assign tail_edge = BXW'(eb_q) * BXW'(BLOCK_WIDTH);

  // sequencer
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    clr_cnt_d    = clr_cnt_q;
    sb_d         = sb_q;
    eb_d         = eb_q;
    head_last_d  = head_last_q;
    tail_first_d = tail_first_q;
    idx_d        = idx_q;
    bidx_d       = bidx_q;
    rdv_d        = 1'b0;
    rdsrc_d      = rdsrc_q;
    diff_d       = diff_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_sum_d    = out_sum_q;
    out_err_d    = out_err_q;

    el_we     = 1'b0;
    el_waddr  = pos_q[AW-1:0];
    el_wdata  = value_q;
    el_re     = 1'b0;
    el_raddr  = idx_q;
    blk_we    = 1'b0;
    blk_waddr = sb_q;
    blk_wdata = blk_rdata + diff_q;
    blk_re    = 1'b0;
    blk_raddr = bidx_q;

    // reads issued last cycle land here
    acc_d = rdv_q ? acc_q + (rdsrc_q ? blk_rdata : el_rdata) : acc_q;

    unique case (state_q)
      StClear: begin
        el_we     = 1'b1;
        el_waddr  = clr_cnt_q;
        el_wdata  = '0;
        blk_we    = (AW + 1)'(clr_cnt_q) < (AW + 1)'(NB);
        blk_waddr = BAW'(clr_cnt_q);
        blk_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_accept) begin
          state_d = StDecode;
        end
      end
      StDecode: begin
        sb_d = sb_prod[SH +: BAW];
        eb_d = eb_prod[SH +: BAW];
        case (cmd_q)
          CmdWrite, CmdAdd: begin
            state_d = pos_out ? StIdle : StRead;
          end
          CmdQuery: begin
            acc_d = '0;
            err_d = 1'b0;
            if (pos_q > end_q) begin
              err_d   = 1'b1;
              state_d = StResult;
            end else if (pos_out) begin
              state_d = StResult;
            end else begin
              state_d = StBound;
            end
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      StBound: begin
        head_last_d  = (sb_q == eb_q) ? end_c : AW'(head_edge);
        tail_first_d = AW'(tail_edge);
        idx_d        = pos_q[AW-1:0];
        bidx_d       = sb_q + BAW'(1);
        phase_d      = PhHead;
        acc_d        = '0;
        state_d      = StScan;
      end
      StRead: begin
        el_re    = 1'b1;
        el_raddr = pos_q[AW-1:0];
        blk_re   = 1'b1;
        blk_raddr = sb_q;
        state_d  = StUpdate;
      end
      StUpdate: begin
        // element gets the new value, block sum moves by the difference
        el_we = 1'b1;
        if (cmd_q == CmdWrite) begin
          el_wdata = value_q;
          diff_d   = value_q - el_rdata;
        end else begin
          el_wdata = el_rdata + value_q;
          diff_d   = value_q;
        end
        state_d = StBlkWr;
      end
      StBlkWr: begin
        blk_we  = 1'b1;
        state_d = StIdle;
      end
      StScan: begin
        rdv_d = 1'b1;
        unique case (phase_q)
          PhHead: begin
            el_re   = 1'b1;
            rdsrc_d = 1'b0;
            if (idx_q == head_last_q) begin
              if (sb_q == eb_q) begin
                state_d = StDrain;
              end else if (sb_q + BAW'(1) == eb_q) begin
                phase_d = PhTail;
                idx_d   = tail_first_q;
              end else begin
                phase_d = PhBlocks;
              end
            end else begin
              idx_d = idx_q + AW'(1);
            end
          end
          PhBlocks: begin
            blk_re  = 1'b1;
            rdsrc_d = 1'b1;
            if (bidx_q == eb_q - BAW'(1)) begin
              phase_d = PhTail;
              idx_d   = tail_first_q;
            end else begin
              bidx_d = bidx_q + BAW'(1);
            end
          end
          PhTail: begin
            el_re   = 1'b1;
            rdsrc_d = 1'b0;
            if (idx_q == end_c) begin
              state_d = StDrain;
            end else begin
              idx_d = idx_q + AW'(1);
            end
          end
          default: begin
            state_d = StDrain;
          end
        endcase
      end
      StDrain: begin
        state_d = StResult;
      end
      StResult: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          out_err_d   = err_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      phase_q     <= PhHead;
      clr_cnt_q   <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      clr_cnt_q   <= clr_cnt_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_e'(s_axis_tuser);
      pos_q   <= CW'(s_axis_tdata[POS_W-1:0]);
      end_q   <= CW'(s_axis_tdata[2*POS_W-1:POS_W]);
      value_q <= s_axis_tdata[2*POS_W +: DATA_W];
    end
    sb_q         <= sb_d;
    eb_q         <= eb_d;
    head_last_q  <= head_last_d;
    tail_first_q <= tail_first_d;
    idx_q        <= idx_d;
    bidx_q       <= bidx_d;
    rdsrc_q      <= rdsrc_d;
    acc_q        <= acc_d;
    diff_q       <= diff_d;
    err_q        <= err_d;
    out_sum_q    <= out_sum_d;
    out_err_q    <= out_err_d;
  end

  // element memory
  brs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_el_ram (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .waddr_i (el_waddr),
    .wdata_i (el_wdata),
    .re_i    (el_re),
    .raddr_i (el_raddr),
    .rdata_o (el_rdata)
  );

  // block sum memory
  brs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NB)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .re_i    (blk_re),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sum_q;
  assign m_axis_tuser  = out_err_q;

endmodule

// ===== rtl/brs_checker.sv =====
// Port-level checker for the block-decomposed range-sum store, bound to the top.
// Depends on brs_pkg and block_decomposed_range_sum.
module brs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [brs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input logic [brs_pkg::CMD_W-1:0]      s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [brs_pkg::DATA_W-1:0]     m_axis_tdata,
  input logic                           m_axis_tuser
);
  import brs_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // an error result carries a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result with nonzero sum");

  // one command word in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while one is in work");

  // clearing pass right after reset: no words in or out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready && !m_axis_tvalid)
    else $error("stream active during clearing pass");

endmodule

bind block_decomposed_range_sum brs_checker u_brs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
